/* design/mpl_pkg.sv */
// Shared types for the LPT multiway partitioner: datapath operation codes,
// controller status bundle and fixed field widths.
// No dependencies.
package mpl_pkg;

  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_RESET = 2;

  // one operation per cycle, issued by the controller to the datapath
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_PUT,
    OP_INS_RD,
    OP_INS_CMP,
    OP_CLR,
    OP_MIN_INIT,
    OP_MIN_STEP,
    OP_DEAL_WR,
    OP_I_CLR,
    OP_RD,
    OP_MV_CHK,
    OP_MV_W2,
    OP_MAX_INIT,
    OP_MAX_STEP,
    OP_K_CLR,
    OP_SW_CHKI,
    OP_RDJ,
    OP_I_INC,
    OP_SW_CHKJ,
    OP_SW_W2,
    OP_SW_CNT,
    OP_OUT_LD,
    OP_OUT_ACC
  } op_e;

  typedef struct packed {
    logic full;       // task store holds MAX_TASKS entries
    logic j_zero;     // insertion slot reached the front
    logic shift;      // entry read ahead of the slot is shorter than the new task
    logic last;       // current item carried tlast
    logic scan_end;   // group scan counter reached the group count
    logic i_last;     // task pointer is on the last stored task
    logic i_end;      // task pointer is past the last stored task
    logic j_end;      // swap partner pointer is past the last stored task
    logic k_last;     // swap budget used up after this one
    logic mv_hit;     // read task may move to the lightest group
    logic sw_hit;     // read partner may swap with the held task
    logic is_hg;      // read task sits in the heaviest group
    logic out_final;  // held result is the last of the set
  } status_t;

endpackage

/* design/multiway_partition_lpt_local_search.sv */
// Channel   | dir | handshake                    | contents
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: duration; tlast: last of set
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: task_index, task_length,
//           |     |                              |   assigned_group; tlast: final_res
// cfg       | in  | cfg_we_i                     | cfg_wdata_i: num_groups
// Load: each item is inserted into the sorted task memory (single read port),
//   moving shorter entries back one at a time to make room.
// After the last item: deal, move tries and swap tries, then the results, each
//   held until the output accepts it.
// Reset (async, low) clears counters, sums and num_groups (to 2); task memories
// are not cleared. tready is high only while idle.
module multiway_partition_lpt_local_search #(
  parameter int unsigned MAX_TASKS     = 64,
  parameter int unsigned MAX_GROUPS    = 16,
  parameter int unsigned DURATION_BITS = 16,
  localparam int unsigned IDX_W = $clog2(MAX_TASKS),
  localparam int unsigned GRP_W = $clog2(MAX_GROUPS),
  localparam int unsigned IN_W  = ((DURATION_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_F = IDX_W + DURATION_BITS + GRP_W,
  localparam int unsigned OUT_W = ((OUT_F + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_W-1:0]           s_axis_tdata,  // duration
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata,  // task_index, task_length, assigned_group
  output logic                      m_axis_tlast,
  input  logic                      cfg_we_i,
  input  logic [mpl_pkg::CFG_W-1:0] cfg_wdata_i
);

  mpl_pkg::op_e             op;
  mpl_pkg::status_t         status;
  logic [IDX_W-1:0]         out_idx;
  logic [DURATION_BITS-1:0] out_len;
  logic [GRP_W-1:0]         out_grp;

  mpl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .in_ready_o  (s_axis_tready),
    .op_o        (op)
  );

  mpl_dp #(
    .MAX_TASKS     (MAX_TASKS),
    .MAX_GROUPS    (MAX_GROUPS),
    .DURATION_BITS (DURATION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_data_i   (s_axis_tdata[DURATION_BITS-1:0]),
    .in_last_i   (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_idx_o   (out_idx),
    .out_len_o   (out_len),
    .out_grp_o   (out_grp),
    .out_last_o  (m_axis_tlast),
    .status_o    (status)
  );

  assign m_axis_tdata = OUT_W'({out_grp, out_len, out_idx});

endmodule

/* design/mpl_dp.sv */
// Datapath of the LPT partitioner: task memories, group sums, scan counters
// and the output register. Driven by mpl_ctrl through mpl_pkg::op_e.
// Depends on mpl_pkg.
module mpl_dp #(
  parameter int unsigned MAX_TASKS     = 64,
  parameter int unsigned MAX_GROUPS    = 16,
  parameter int unsigned DURATION_BITS = 16,
  localparam int unsigned IDX_W = $clog2(MAX_TASKS),
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1),
  localparam int unsigned GRP_W = $clog2(MAX_GROUPS),
  localparam int unsigned NG_W  = $clog2(MAX_GROUPS + 1),
  localparam int unsigned TOT_W = DURATION_BITS + IDX_W,
  localparam int unsigned LT_W  = DURATION_BITS + IDX_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mpl_pkg::op_e                op_i,
  input  logic [DURATION_BITS-1:0]    in_data_i,
  input  logic                        in_last_i,
  input  logic                        cfg_we_i,
  input  logic [mpl_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                        out_valid_o,
  output logic [IDX_W-1:0]            out_idx_o,
  output logic [DURATION_BITS-1:0]    out_len_o,
  output logic [GRP_W-1:0]            out_grp_o,
  output logic                        out_last_o,
  output mpl_pkg::status_t            status_o
);

  logic [mpl_pkg::CFG_W-1:0] cfg_q;
  logic [NG_W-1:0]           ng;
  logic [CNT_W-1:0]          cnt_q, i_q, jj_q, k_q;
  logic [IDX_W-1:0]          ip_q;
  logic [DURATION_BITS-1:0]  kl_q, li_q;
  logic                      last_q;
  logic [NG_W-1:0]           g_q;
  logic [GRP_W-1:0]          best_q, hg_q, gj_q;
  logic [TOT_W-1:0]          bsum_q, hsum_q, tj_q;
  logic                      jsel_q;
  logic [TOT_W-1:0]          tot_q [MAX_GROUPS];

  logic [LT_W-1:0]           mem_lt [MAX_TASKS];
  logic [GRP_W-1:0]          mem_g  [MAX_TASKS];
  logic [LT_W-1:0]           rd_lt_q;
  logic [GRP_W-1:0]          rd_g_q;

  logic                      out_valid_q, fin_q;
  logic [IDX_W-1:0]          out_idx_q;
  logic [DURATION_BITS-1:0]  out_len_q;
  logic [GRP_W-1:0]          out_grp_q;

  logic [DURATION_BITS-1:0]  rd_len;
  logic [IDX_W-1:0]          rd_tag;
  logic [GRP_W-1:0]          g_idx, tot_addr;
  logic [TOT_W-1:0]          tot_rd, deal_sum;
  logic [DURATION_BITS-1:0]  dlt;
  logic [TOT_W:0]            mv_sum, sw_sum;
  logic                      mv_hit, sw_hit, shift;

  logic [IDX_W-1:0]          m_raddr;
  logic                      lt_we, g_we, t_we;
  logic [IDX_W-1:0]          lt_waddr, g_waddr;
  logic [LT_W-1:0]           lt_wdata;
  logic [GRP_W-1:0]          g_wdata, t_waddr;
  logic [TOT_W-1:0]          t_wdata;

  // group count: zero reads as one, large values saturate
  always_comb begin
    if (cfg_q == '0) begin
      ng = NG_W'(1);
    end else if (32'(cfg_q) > MAX_GROUPS) begin
      ng = NG_W'(MAX_GROUPS);
    end else begin
      ng = NG_W'(cfg_q);
    end
  end

  assign rd_len   = rd_lt_q[LT_W-1:IDX_W];
  assign rd_tag   = rd_lt_q[IDX_W-1:0];
  assign g_idx    = g_q[GRP_W-1:0];
  assign tot_addr = jsel_q ? rd_g_q : g_idx;
  assign tot_rd   = tot_q[tot_addr];
  assign deal_sum = bsum_q + TOT_W'(rd_len);
  assign dlt      = li_q - rd_len;
  assign mv_sum   = {1'b0, bsum_q} + (TOT_W+1)'(rd_len);
  assign sw_sum   = {1'b0, tot_rd} + (TOT_W+1)'(dlt);
  assign mv_hit   = (rd_g_q == hg_q) && (mv_sum < {1'b0, hsum_q});
  assign sw_hit   = (rd_g_q != hg_q) && (li_q != rd_len) && (sw_sum < {1'b0, hsum_q});
  assign shift    = rd_len < kl_q;

  always_comb begin
    case (op_i)
      mpl_pkg::OP_INS_RD: m_raddr = ip_q - IDX_W'(1);
      mpl_pkg::OP_RDJ:    m_raddr = jj_q[IDX_W-1:0];
      default:            m_raddr = i_q[IDX_W-1:0];
    endcase
  end

  always_comb begin
    lt_we    = (op_i == mpl_pkg::OP_INS_PUT) || (op_i == mpl_pkg::OP_INS_CMP);
    lt_waddr = ip_q;
    lt_wdata = ((op_i == mpl_pkg::OP_INS_CMP) && shift) ? rd_lt_q
                                                        : {kl_q, cnt_q[IDX_W-1:0]};
    g_we    = 1'b0;
    g_waddr = i_q[IDX_W-1:0];
    g_wdata = best_q;
    t_we    = 1'b0;
    t_waddr = best_q;
    t_wdata = deal_sum;
    case (op_i)
      mpl_pkg::OP_DEAL_WR: begin
        g_we = 1'b1;
        t_we = 1'b1;
      end
      mpl_pkg::OP_MV_CHK: begin
        g_we    = mv_hit;
        t_we    = mv_hit;
        t_waddr = hg_q;
        t_wdata = hsum_q - TOT_W'(rd_len);
      end
      mpl_pkg::OP_MV_W2: begin
        t_we    = 1'b1;
        t_wdata = bsum_q + TOT_W'(li_q);
      end
      mpl_pkg::OP_SW_CHKJ: begin
        g_we    = sw_hit;
        g_wdata = rd_g_q;
        t_we    = sw_hit;
        t_waddr = hg_q;
        t_wdata = hsum_q - TOT_W'(dlt);
      end
      mpl_pkg::OP_SW_W2: begin
        g_we    = 1'b1;
        g_waddr = jj_q[IDX_W-1:0];
        g_wdata = hg_q;
        t_we    = 1'b1;
        t_waddr = gj_q;
        t_wdata = tj_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (lt_we) begin
      mem_lt[lt_waddr] <= lt_wdata;
    end
    if (g_we) begin
      mem_g[g_waddr] <= g_wdata;
    end
    rd_lt_q <= mem_lt[m_raddr];
    rd_g_q  <= mem_g[m_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned n = 0; n < MAX_GROUPS; n++) begin
        tot_q[n] <= '0;
      end
    end else if (op_i == mpl_pkg::OP_CLR) begin
      for (int unsigned n = 0; n < MAX_GROUPS; n++) begin
        tot_q[n] <= '0;
      end
    end else if (t_we) begin
      tot_q[t_waddr] <= t_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= mpl_pkg::CFG_W'(mpl_pkg::CFG_RESET);
      cnt_q       <= '0;
      ip_q        <= '0;
      last_q      <= 1'b0;
      i_q         <= '0;
      jj_q        <= '0;
      k_q         <= '0;
      g_q         <= '0;
      best_q      <= '0;
      bsum_q      <= '0;
      hg_q        <= '0;
      hsum_q      <= '0;
      li_q        <= '0;
      gj_q        <= '0;
      tj_q        <= '0;
      jsel_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      jsel_q <= (op_i == mpl_pkg::OP_RDJ);
      case (op_i)
        mpl_pkg::OP_LOAD: begin
          last_q <= in_last_i;
          ip_q   <= cnt_q[IDX_W-1:0];
        end
        mpl_pkg::OP_INS_PUT: cnt_q <= cnt_q + CNT_W'(1);
        mpl_pkg::OP_INS_CMP: begin
          if (shift) begin
            ip_q <= ip_q - IDX_W'(1);
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        mpl_pkg::OP_CLR: begin
          hg_q   <= '0;
          hsum_q <= '0;
          i_q    <= '0;
        end
        mpl_pkg::OP_MIN_INIT: begin
          best_q <= '0;
          bsum_q <= '1;   // above any reachable sum
          g_q    <= '0;
        end
        mpl_pkg::OP_MIN_STEP: begin
          if (tot_rd < bsum_q) begin
            best_q <= g_idx;
            bsum_q <= tot_rd;
          end
          g_q <= g_q + NG_W'(1);
        end
        mpl_pkg::OP_DEAL_WR: begin
          if (deal_sum > hsum_q) begin
            hg_q   <= best_q;
            hsum_q <= deal_sum;
          end else if (best_q == hg_q) begin
            hsum_q <= deal_sum;
          end
          i_q <= i_q + CNT_W'(1);
        end
        mpl_pkg::OP_I_CLR: i_q <= '0;
        mpl_pkg::OP_MV_CHK: begin
          if (mv_hit) begin
            li_q <= rd_len;
          end else begin
            i_q <= i_q + CNT_W'(1);
          end
        end
        mpl_pkg::OP_MAX_INIT: begin
          hg_q   <= '0;
          hsum_q <= '0;
          g_q    <= '0;
        end
        mpl_pkg::OP_MAX_STEP: begin
          if (tot_rd > hsum_q) begin
            hg_q   <= g_idx;
            hsum_q <= tot_rd;
          end
          g_q <= g_q + NG_W'(1);
        end
        mpl_pkg::OP_K_CLR: begin
          k_q <= '0;
          i_q <= '0;
        end
        mpl_pkg::OP_SW_CHKI: begin
          if (rd_g_q == hg_q) begin
            li_q <= rd_len;
            jj_q <= i_q + CNT_W'(1);
          end else begin
            i_q <= i_q + CNT_W'(1);
          end
        end
        mpl_pkg::OP_I_INC: i_q <= i_q + CNT_W'(1);
        mpl_pkg::OP_SW_CHKJ: begin
          if (sw_hit) begin
            gj_q <= rd_g_q;
            tj_q <= tot_rd + TOT_W'(dlt);
          end else begin
            jj_q <= jj_q + CNT_W'(1);
          end
        end
        mpl_pkg::OP_SW_CNT: begin
          k_q <= k_q + CNT_W'(1);
          i_q <= '0;
        end
        mpl_pkg::OP_OUT_LD: begin
          out_valid_q <= 1'b1;
          fin_q       <= ({1'b0, i_q} + (CNT_W+1)'(1)) == {1'b0, cnt_q};
        end
        mpl_pkg::OP_OUT_ACC: begin
          out_valid_q <= 1'b0;
          if (fin_q) begin
            cnt_q <= '0;
          end else begin
            i_q <= i_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == mpl_pkg::OP_LOAD) begin
      kl_q <= in_data_i;
    end
    if (op_i == mpl_pkg::OP_OUT_LD) begin
      out_idx_q <= rd_tag;
      out_len_q <= rd_len;
      out_grp_q <= rd_g_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_idx_o   = out_idx_q;
  assign out_len_o   = out_len_q;
  assign out_grp_o   = out_grp_q;
  assign out_last_o  = fin_q;

  always_comb begin
    status_o.full      = cnt_q == CNT_W'(MAX_TASKS);
    status_o.j_zero    = ip_q == '0;
    status_o.shift     = shift;
    status_o.last      = last_q;
    status_o.scan_end  = g_q == ng;
    status_o.i_last    = ({1'b0, i_q} + (CNT_W+1)'(1)) == {1'b0, cnt_q};
    status_o.i_end     = i_q == cnt_q;
    status_o.j_end     = jj_q == cnt_q;
    status_o.k_last    = ({1'b0, k_q} + (CNT_W+1)'(1)) == {1'b0, cnt_q};
    status_o.mv_hit    = mv_hit;
    status_o.sw_hit    = sw_hit;
    status_o.is_hg     = rd_g_q == hg_q;
    status_o.out_final = fin_q;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_TASKS))
    else $error("task count above capacity");

  a_out_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (i_q < cnt_q))
    else $error("result pointer outside stored set");

  a_set_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == mpl_pkg::OP_OUT_ACC && fin_q) |=> (cnt_q == '0 && !out_valid_q))
    else $error("set not retired after final result");

  a_move_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == mpl_pkg::OP_MV_CHK && mv_hit) |-> (best_q != hg_q))
    else $error("move into the heaviest group");

endmodule

/* design/mpl_ctrl.sv */
// Controller of the LPT partitioner: one-hot sequencer over load/insert,
// deal, move search, swap search and result phases.
// Depends on mpl_pkg.
module mpl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  input  logic             out_ready_i,
  input  mpl_pkg::status_t status_i,
  output logic             in_ready_o,
  output mpl_pkg::op_e     op_o
);

  typedef enum logic [22:0] {
    S_IDLE    = 23'd1 << 0,
    S_INS_RD  = 23'd1 << 1,
    S_INS_CMP = 23'd1 << 2,
    S_CLR     = 23'd1 << 3,
    S_DL_MIN0 = 23'd1 << 4,
    S_DL_MIN  = 23'd1 << 5,
    S_MV_MIN0 = 23'd1 << 6,
    S_MV_MIN  = 23'd1 << 7,
    S_MV_RD   = 23'd1 << 8,
    S_MV_CHK  = 23'd1 << 9,
    S_MV_W2   = 23'd1 << 10,
    S_MV_MAX0 = 23'd1 << 11,
    S_MV_MAX  = 23'd1 << 12,
    S_SW_RDI  = 23'd1 << 13,
    S_SW_CHKI = 23'd1 << 14,
    S_SW_RDJ  = 23'd1 << 15,
    S_SW_CHKJ = 23'd1 << 16,
    S_SW_W2   = 23'd1 << 17,
    S_SW_MAX0 = 23'd1 << 18,
    S_SW_MAX  = 23'd1 << 19,
    S_OUT_RD  = 23'd1 << 20,
    S_OUT_LD  = 23'd1 << 21,
    S_OUT_WT  = 23'd1 << 22
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = mpl_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = mpl_pkg::OP_LOAD;
          if (!status_i.full) begin
            state_d = S_INS_RD;
          end else if (in_last_i) begin
            state_d = S_CLR;   // dropped item still closes the set
          end
        end
      end
      S_INS_RD: begin
        if (status_i.j_zero) begin
          op_o    = mpl_pkg::OP_INS_PUT;
          state_d = status_i.last ? S_CLR : S_IDLE;
        end else begin
          op_o    = mpl_pkg::OP_INS_RD;
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        op_o = mpl_pkg::OP_INS_CMP;
        if (status_i.shift) begin
          state_d = S_INS_RD;
        end else begin
          state_d = status_i.last ? S_CLR : S_IDLE;
        end
      end
      S_CLR: begin
        op_o    = mpl_pkg::OP_CLR;
        state_d = S_DL_MIN0;
      end
      S_DL_MIN0: begin
        op_o    = mpl_pkg::OP_MIN_INIT;
        state_d = S_DL_MIN;
      end
      S_DL_MIN: begin
        if (status_i.scan_end) begin
          op_o    = mpl_pkg::OP_DEAL_WR;
          state_d = status_i.i_last ? S_MV_MIN0 : S_DL_MIN0;
        end else begin
          op_o = mpl_pkg::OP_MIN_STEP;
        end
      end
      S_MV_MIN0: begin
        op_o    = mpl_pkg::OP_MIN_INIT;
        state_d = S_MV_MIN;
      end
      S_MV_MIN: begin
        if (status_i.scan_end) begin
          op_o    = mpl_pkg::OP_I_CLR;
          state_d = S_MV_RD;
        end else begin
          op_o = mpl_pkg::OP_MIN_STEP;
        end
      end
      S_MV_RD: begin
        if (status_i.i_end) begin
          op_o    = mpl_pkg::OP_K_CLR;
          state_d = S_SW_RDI;
        end else begin
          op_o    = mpl_pkg::OP_RD;
          state_d = S_MV_CHK;
        end
      end
      S_MV_CHK: begin
        op_o    = mpl_pkg::OP_MV_CHK;
        state_d = status_i.mv_hit ? S_MV_W2 : S_MV_RD;
      end
      S_MV_W2: begin
        op_o    = mpl_pkg::OP_MV_W2;
        state_d = S_MV_MAX0;
      end
      S_MV_MAX0: begin
        op_o    = mpl_pkg::OP_MAX_INIT;
        state_d = S_MV_MAX;
      end
      S_MV_MAX: begin
        if (status_i.scan_end) begin
          state_d = S_MV_MIN0;
        end else begin
          op_o = mpl_pkg::OP_MAX_STEP;
        end
      end
      S_SW_RDI: begin
        if (status_i.i_end) begin
          op_o    = mpl_pkg::OP_I_CLR;   // no swap found
          state_d = S_OUT_RD;
        end else begin
          op_o    = mpl_pkg::OP_RD;
          state_d = S_SW_CHKI;
        end
      end
      S_SW_CHKI: begin
        op_o    = mpl_pkg::OP_SW_CHKI;
        state_d = status_i.is_hg ? S_SW_RDJ : S_SW_RDI;
      end
      S_SW_RDJ: begin
        if (status_i.j_end) begin
          op_o    = mpl_pkg::OP_I_INC;
          state_d = S_SW_RDI;
        end else begin
          op_o    = mpl_pkg::OP_RDJ;
          state_d = S_SW_CHKJ;
        end
      end
      S_SW_CHKJ: begin
        op_o    = mpl_pkg::OP_SW_CHKJ;
        state_d = status_i.sw_hit ? S_SW_W2 : S_SW_RDJ;
      end
      S_SW_W2: begin
        op_o    = mpl_pkg::OP_SW_W2;
        state_d = S_SW_MAX0;
      end
      S_SW_MAX0: begin
        op_o    = mpl_pkg::OP_MAX_INIT;
        state_d = S_SW_MAX;
      end
      S_SW_MAX: begin
        if (!status_i.scan_end) begin
          op_o = mpl_pkg::OP_MAX_STEP;
        end else if (status_i.k_last) begin
          op_o    = mpl_pkg::OP_I_CLR;
          state_d = S_OUT_RD;
        end else begin
          op_o    = mpl_pkg::OP_SW_CNT;
          state_d = S_SW_RDI;
        end
      end
      S_OUT_RD: begin
        op_o    = mpl_pkg::OP_RD;
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        op_o    = mpl_pkg::OP_OUT_LD;
        state_d = S_OUT_WT;
      end
      S_OUT_WT: begin
        if (out_ready_i) begin
          op_o    = mpl_pkg::OP_OUT_ACC;
          state_d = status_i.out_final ? S_IDLE : S_OUT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input ready outside idle");

  a_out_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT_WT && out_ready_i && status_i.out_final) |=> (state_q == S_IDLE))
    else $error("did not return to idle after last result");

endmodule
